// ----- rtl/clock_control_register_block_macros.svh -----
// Assertion macros used by the checker file.
`ifndef CLOCK_CONTROL_REGISTER_BLOCK_MACROS_SVH
`define CLOCK_CONTROL_REGISTER_BLOCK_MACROS_SVH

// Implication in the same cycle, off while reset is high.
`define CCRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, off while reset is high.
`define CCRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Implication in the next cycle, checked during reset too.
`define CCRB_ASSERT_NEXT_ANY(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ccrb_pkg.sv -----
// Types, constants and tables of the clock control register block.
`default_nettype none
package ccrb_pkg;

   localparam logic [31:0] HSI_HZ         = 32'd16000000;
   localparam logic [31:0] MSI_DEFAULT_HZ = 32'd100000;
   localparam logic [31:0] CTRL_RW_MASK   = 32'h010101F1;
   localparam logic [31:0] CTRL_RDY_MASK  = 32'h02020202;
   localparam logic [31:0] SEL_RW_MASK    = 32'h00003FF3;
   localparam logic [31:0] SEL_SWS_MASK   = 32'h0000000C;
   localparam logic [31:0] CTRL_RESET     = 32'h00000300;
   localparam logic [31:0] PLL_RESET      = 32'h00001000;
   localparam logic [25:0] EXT_OSC_RESET  = 26'd8000000;
   localparam int unsigned PLAIN_COUNT    = 11;
   localparam int unsigned PLAIN_IDX_W    = 4;

   localparam logic [9:0] OFF_CTRL = 10'h000;
   localparam logic [9:0] OFF_SEL  = 10'h004;
   localparam logic [9:0] OFF_PLL  = 10'h060;

   localparam logic [1:0] SW_MSI = 2'd0;
   localparam logic [1:0] SW_HSI = 2'd1;
   localparam logic [1:0] SW_HSE = 2'd2;
   localparam logic [1:0] SW_PLL = 2'd3;

   localparam logic [1:0] PLLSRC_NONE = 2'd0;
   localparam logic [1:0] PLLSRC_MSI  = 2'd1;
   localparam logic [1:0] PLLSRC_HSI  = 2'd2;
   localparam logic [1:0] PLLSRC_HSE  = 2'd3;

   typedef enum logic [2:0] {
      KIND_CTRL,
      KIND_SEL,
      KIND_PLL,
      KIND_PLAIN,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic                   write;
      kind_type               kind;
      logic [PLAIN_IDX_W-1:0] plain_idx;
      logic [31:0]            wdata;
   } entry_type;

   function automatic logic [31:0] msi_hz(input logic [3:0] range);
      logic [31:0] hz;
      unique case (range)
         4'd0:    hz = 32'd100000;
         4'd1:    hz = 32'd200000;
         4'd2:    hz = 32'd400000;
         4'd3:    hz = 32'd800000;
         4'd4:    hz = 32'd1000000;
         4'd5:    hz = 32'd2000000;
         4'd6:    hz = 32'd4000000;
         4'd7:    hz = 32'd8000000;
         4'd8:    hz = 32'd16000000;
         4'd9:    hz = 32'd24000000;
         4'd10:   hz = 32'd32000000;
         4'd11:   hz = 32'd48000000;
         default: hz = MSI_DEFAULT_HZ;
      endcase
      return hz;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ccrb_front.sv -----
// Front end: decodes the register offset of an incoming access.
`default_nettype none
module ccrb_front
   import ccrb_pkg::*;
(
   input  wire logic        func,
   input  wire logic [9:0]  reg_offset,
   input  wire logic [31:0] write_data,
   output entry_type        entry
);

   always_comb begin
      entry.write     = func;
      entry.wdata     = write_data;
      entry.plain_idx = '0;
      entry.kind      = KIND_NONE;
      priority case (reg_offset)
         OFF_CTRL: entry.kind = KIND_CTRL;
         OFF_SEL:  entry.kind = KIND_SEL;
         OFF_PLL:  entry.kind = KIND_PLL;
         10'h008:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd0;  end
         10'h00C:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd1;  end
         10'h010:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd2;  end
         10'h014:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd3;  end
         10'h018:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd4;  end
         10'h01C:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd5;  end
         10'h020:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd6;  end
         10'h024:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd7;  end
         10'h04C:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd8;  end
         10'h058:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd9;  end
         10'h094:  begin entry.kind = KIND_PLAIN; entry.plain_idx = 4'd10; end
         default:  entry.kind = KIND_NONE;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/ccrb_fifo.sv -----
// Two-entry queue of decoded accesses between front and back end.
`default_nettype none
module ccrb_fifo
   import ccrb_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  entry_type  push_data,
   output logic       full,
   input  wire logic  pop,
   output entry_type  pop_data,
   output logic       empty
);

   entry_type   mem_ff [2];
   logic        wptr_ff, wptr_in;
   logic        rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ccrb_div.sv -----
// Iterative divider: 32-bit dividend by a divisor of 1 to 15, one bit a cycle.
`default_nettype none
module ccrb_div
   import ccrb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [3:0]  divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic [31:0] quo_ff;
   logic [3:0]  rem_ff;
   logic [3:0]  dvs_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  trial;
   logic        take;

   assign trial    = {rem_ff, quo_ff[31]};
   assign take     = (trial >= {1'b0, dvs_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= take ? 4'(trial - {1'b0, dvs_ff}) : trial[3:0];
         quo_ff  <= {quo_ff[30:0], take};
         cnt_ff  <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ccrb_back.sv -----
// Back end: register bank update, clock frequency computation and result slot.
`default_nettype none
module ccrb_back
   import ccrb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  entry_type        entry,
   input  wire logic        entry_empty,
   output logic             entry_pop,
   input  wire logic        csr_valid,
   input  wire logic [25:0] csr_external_osc_hz,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_bad_offset,
   output logic [31:0]      rsp_sysclk_hz,
   output logic [31:0]      rsp_hclk_hz,
   output logic [31:0]      rsp_pclk1_hz,
   output logic [31:0]      rsp_pclk2_hz
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLL,
      ST_DIV1,
      ST_DIV2,
      ST_OUT
   } state_type;

   state_type   state_ff;
   logic [25:0] ext_ff;
   logic [31:0] ctrl_ff, sel_ff, pll_ff;
   logic [31:0] plain_ff [PLAIN_COUNT];
   logic [31:0] rd_ff;
   logic        bad_ff;
   logic [31:0] pllhz_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_rd_ff, out_sys_ff, out_hclk_ff, out_p1_ff, out_p2_ff;
   logic        out_bad_ff;

   logic [31:0] ctrl_in, sel_in, v;
   logic [31:0] msi, src, sys, hclk;
   logic [3:0]  hpre, hsh;
   logic [2:0]  pre1, pre2, s1, s2;
   logic        pll_run;
   logic        div_start, div_done;
   logic [31:0] div_dividend, div_quo, vco;
   logic [3:0]  div_divisor;
   logic        out_free;

   assign v = entry.wdata;

   // Control word: masked write, ready bits follow the enable bits
   always_comb begin
      ctrl_in = ((ctrl_ff & ~CTRL_RW_MASK) | (v & CTRL_RW_MASK)) & ~CTRL_RDY_MASK;
      ctrl_in[9]  = v[8];
      ctrl_in[1]  = v[0];
      ctrl_in[17] = v[16];
      ctrl_in[25] = v[24];
   end

   // Clock select: switch status tracks the switch field when it changes
   always_comb begin
      sel_in = (v & SEL_RW_MASK) | (sel_ff & SEL_SWS_MASK);
      if (sel_ff[1:0] != sel_in[1:0]) begin
         sel_in[3:2] = sel_in[1:0];
      end
   end

   always_comb begin
      msi = MSI_DEFAULT_HZ;
      if (ctrl_ff[8] && ctrl_ff[9]) begin
         msi = msi_hz(ctrl_ff[7:4]);
      end
      unique case (pll_ff[1:0])
         PLLSRC_MSI:  src = msi;
         PLLSRC_HSI:  src = HSI_HZ;
         PLLSRC_HSE:  src = {6'd0, ext_ff};
         PLLSRC_NONE: src = '0;
         default:     src = '0;
      endcase
      pll_run = ctrl_ff[24] && ctrl_ff[25] && (src != '0);

      sys = HSI_HZ;
      unique case (sel_ff[1:0])
         SW_MSI:  sys = msi;
         SW_HSI:  sys = HSI_HZ;
         SW_HSE:  if (ctrl_ff[16] && ctrl_ff[17]) sys = {6'd0, ext_ff};
         SW_PLL:  if (pllhz_ff != '0) sys = pllhz_ff;
         default: sys = HSI_HZ;
      endcase
      hpre = sel_ff[7:4];
      pre1 = sel_ff[10:8];
      pre2 = sel_ff[13:11];
      hsh  = hpre[3] ? (hpre - 4'd7) : 4'd0;
      s1   = pre1[2] ? (pre1 - 3'd3) : 3'd0;
      s2   = pre2[2] ? (pre2 - 3'd3) : 3'd0;
      hclk = sys >> hsh;
   end

   // VCO wraps at 32 bits; halve it so the second pass divides by R+1
   assign vco = 32'(div_quo * {25'd0, pll_ff[14:8]});

   always_comb begin
      div_start    = 1'b0;
      div_dividend = src;
      div_divisor  = {1'b0, pll_ff[6:4]} + 4'd1;
      if (state_ff == ST_PLL) begin
         div_start = pll_run;
      end else if (state_ff == ST_DIV1 && div_done) begin
         div_start    = 1'b1;
         div_dividend = {1'b0, vco[31:1]};
         div_divisor  = {2'd0, pll_ff[26:25]} + 4'd1;
      end
   end

   ccrb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign out_free     = !out_valid_ff || rsp_pop;
   assign entry_pop    = (state_ff == ST_IDLE) && !entry_empty;
   // Load a new item into the slot, or hold the waiting one until popped
   assign out_valid_in = ((state_ff == ST_OUT) && out_free) || (out_valid_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ext_ff       <= EXT_OSC_RESET;
         ctrl_ff      <= CTRL_RESET;
         sel_ff       <= '0;
         pll_ff       <= PLL_RESET;
         for (int i = 0; i < PLAIN_COUNT; i++) begin
            plain_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            ext_ff <= csr_external_osc_hz;
         end
         out_valid_ff <= out_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (!entry_empty) begin
                  bad_ff   <= (entry.kind == KIND_NONE);
                  state_ff <= ST_PLL;
                  unique case (entry.kind)
                     KIND_CTRL: begin
                        if (entry.write) ctrl_ff <= ctrl_in;
                        rd_ff <= entry.write ? '0 : ctrl_ff;
                     end
                     KIND_SEL: begin
                        if (entry.write) sel_ff <= sel_in;
                        rd_ff <= entry.write ? '0 : sel_ff;
                     end
                     KIND_PLL: begin
                        if (entry.write) pll_ff <= v;
                        rd_ff <= entry.write ? '0 : pll_ff;
                     end
                     KIND_PLAIN: begin
                        if (entry.write) plain_ff[entry.plain_idx] <= v;
                        rd_ff <= entry.write ? '0 : plain_ff[entry.plain_idx];
                     end
                     default: rd_ff <= '0;
                  endcase
               end
            end
            ST_PLL: begin
               pllhz_ff <= '0;
               state_ff <= pll_run ? ST_DIV1 : ST_OUT;
            end
            ST_DIV1: begin
               if (div_done) state_ff <= ST_DIV2;
            end
            ST_DIV2: begin
               if (div_done) begin
                  pllhz_ff <= pll_ff[24] ? div_quo : '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  out_rd_ff    <= rd_ff;
                  out_bad_ff   <= bad_ff;
                  out_sys_ff   <= sys;
                  out_hclk_ff  <= hclk;
                  out_p1_ff    <= hclk >> s1;
                  out_p2_ff    <= hclk >> s2;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_read_data  = out_rd_ff;
   assign rsp_bad_offset = out_bad_ff;
   assign rsp_sysclk_hz  = out_sys_ff;
   assign rsp_hclk_hz    = out_hclk_ff;
   assign rsp_pclk1_hz   = out_p1_ff;
   assign rsp_pclk2_hz   = out_p2_ff;

endmodule
`default_nettype wire

// ----- rtl/clock_control_register_block.sv -----
// Top level of the clock control register block.
//
//   channel  ports                      handshake
//   req      func, reg_offset, data     push / full
//   rsp      read data, flag, clock Hz  pop / empty
//   csr      external_osc_hz            valid / ready
//
// When the PLL runs, a result waits for two passes of the shared divider
// (one bit a cycle, 32-bit dividend); otherwise ST_PLL goes to ST_OUT.
// The back end handles items one at a time. Reset is synchronous.
// It restores state, pointers and configuration, but not data registers.
// A two-entry queue takes accesses while the back end works or the result
// waits; full rises when it holds two. csr_ready is always high.
`default_nettype none
module clock_control_register_block
   import ccrb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_func,
   input  wire logic [9:0]  req_reg_offset,
   input  wire logic [31:0] req_write_data,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_bad_offset,
   output logic [31:0]      rsp_sysclk_hz,
   output logic [31:0]      rsp_hclk_hz,
   output logic [31:0]      rsp_pclk1_hz,
   output logic [31:0]      rsp_pclk2_hz,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [25:0] csr_external_osc_hz
);

   entry_type dec_entry, q_entry;
   logic      q_empty, q_pop;

   assign csr_ready = 1'b1;

   ccrb_front u_front (
      .func       (req_func),
      .reg_offset (req_reg_offset),
      .write_data (req_write_data),
      .entry      (dec_entry)
   );

   ccrb_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (dec_entry),
      .full      (req_full),
      .pop       (q_pop),
      .pop_data  (q_entry),
      .empty     (q_empty)
   );

   ccrb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .entry               (q_entry),
      .entry_empty         (q_empty),
      .entry_pop           (q_pop),
      .csr_valid           (csr_valid),
      .csr_external_osc_hz (csr_external_osc_hz),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_read_data       (rsp_read_data),
      .rsp_bad_offset      (rsp_bad_offset),
      .rsp_sysclk_hz       (rsp_sysclk_hz),
      .rsp_hclk_hz         (rsp_hclk_hz),
      .rsp_pclk1_hz        (rsp_pclk1_hz),
      .rsp_pclk2_hz        (rsp_pclk2_hz)
   );

endmodule
`default_nettype wire

// ----- rtl/ccrb_checker.sv -----
// Port-level checker of the clock control register block, with its bind.
`default_nettype none
`include "clock_control_register_block_macros.svh"
module ccrb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [31:0] rsp_read_data,
   input wire logic        rsp_bad_offset,
   input wire logic [31:0] rsp_sysclk_hz,
   input wire logic [31:0] rsp_hclk_hz,
   input wire logic [31:0] rsp_pclk1_hz
);

   `CCRB_ASSERT_NEXT_ANY(a_reset_empty, clock, reset, rsp_empty, "result after reset")
   `CCRB_ASSERT_NEXT(a_hold, clock, reset, !rsp_empty && !rsp_pop,
      !rsp_empty && $stable(rsp_read_data), "waiting item changed")
   `CCRB_ASSERT_NOW(a_bad_zero, clock, reset, !rsp_empty && rsp_bad_offset,
      rsp_read_data == 32'd0, "bad offset with read data")
   `CCRB_ASSERT_NOW(a_div_order, clock, reset, !rsp_empty,
      rsp_hclk_hz <= rsp_sysclk_hz && rsp_pclk1_hz <= rsp_hclk_hz, "divided clock too fast")

endmodule

bind clock_control_register_block ccrb_checker u_ccrb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_read_data  (rsp_read_data),
   .rsp_bad_offset (rsp_bad_offset),
   .rsp_sysclk_hz  (rsp_sysclk_hz),
   .rsp_hclk_hz    (rsp_hclk_hz),
   .rsp_pclk1_hz   (rsp_pclk1_hz)
);
`default_nettype wire
